// File: src/crclec_pkg.sv
package crclec_pkg;

  // Width of the internal saturating byte counter
  localparam int COUNT_BITS = 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Reflected CRC-16, polynomial 0xA001
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  CHAR_CR  = 8'h0D;
  localparam logic [7:0]  CHAR_LF  = 8'h0A;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LINE_CONV  = 2'd0;
  localparam logic [1:0] REG_DIRECTION  = 2'd1;
  localparam logic [1:0] REG_CRC_ENABLE = 2'd2;

  // Direction codes
  localparam logic DIR_ARCHIVE = 1'b0;
  localparam logic DIR_EXTRACT = 1'b1;

  // Input action codes
  localparam logic ACT_DATA    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Operation codes passed from front to back
  localparam logic [1:0] OP_PASS    = 2'd0;
  localparam logic [1:0] OP_DROP    = 2'd1;
  localparam logic [1:0] OP_EXPAND  = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // Operation queue sizing
  localparam int OPQ_DEPTH    = 4;
  localparam int OPQ_PTR_BITS = 2;
  localparam int OPQ_CNT_BITS = 3;

  typedef struct packed {
    logic line_conv;
    logic direction;
    logic crc_enable;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_present;
    logic [15:0] crc_now;
    logic [31:0] bytes_counted;
    logic        run_last;
    logic        file_end;
  } result_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       final_byte;
  } op_t;

  // One byte through the reflected CRC, bit by bit
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/crclec_front.sv
module crclec_front (
  input  crclec_pkg::cfg_t     cfg,
  input  logic                 push,
  output logic                 full,
  input  crclec_pkg::in_item_t item,
  output logic                 op_push,
  output crclec_pkg::op_t      op,
  input  logic                 opq_full
);
  import crclec_pkg::*;

  // Accept while the operation queue has room
  assign full    = opq_full;
  assign op_push = push & ~opq_full;

  // Classify the byte under the current mode
  always_comb begin
    op.data_byte  = item.data_byte;
    op.final_byte = item.final_byte;
    if (item.action == ACT_RESTART) begin
      op.kind = OP_RESTART;
    end else if (cfg.line_conv && cfg.direction == DIR_ARCHIVE &&
                 item.data_byte == CHAR_LF) begin
      op.kind = OP_EXPAND;
    end else if (cfg.line_conv && cfg.direction == DIR_EXTRACT &&
                 item.data_byte == CHAR_CR) begin
      op.kind = OP_DROP;
    end else begin
      op.kind = OP_PASS;
    end
  end

endmodule

// File: src/crclec_opq.sv
module crclec_opq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  crclec_pkg::op_t op_in,
  output logic            full,
  input  logic            pop,
  output crclec_pkg::op_t op_out,
  output logic            empty
);
  import crclec_pkg::*;

  op_t                     mem [OPQ_DEPTH];
  logic [OPQ_PTR_BITS-1:0] wr_ptr;
  logic [OPQ_PTR_BITS-1:0] rd_ptr;
  logic [OPQ_CNT_BITS-1:0] count;

  assign full   = (count == OPQ_CNT_BITS'(OPQ_DEPTH));
  assign empty  = (count == '0);
  assign op_out = mem[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= op_in;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/crclec_back.sv
module crclec_back (
  input  logic                clk,
  input  logic                rst,
  input  crclec_pkg::cfg_t    cfg,
  input  logic                op_empty,
  input  crclec_pkg::op_t     op,
  output logic                op_pop,
  output logic                empty,
  input  logic                pop,
  output crclec_pkg::result_t result
);
  import crclec_pkg::*;

  logic                  phase;
  logic                  phase_next;
  logic [15:0]           crc;
  logic [15:0]           crc_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;

  logic                  step;
  logic                  first_half;
  logic [7:0]            cur_byte;
  logic [15:0]           crc_cov;
  logic [COUNT_BITS-1:0] cnt_cov;
  result_t               res;

  // Two-entry result buffer
  result_t res_mem [2];
  logic    res_wr_ptr;
  logic    res_rd_ptr;
  logic [1:0] res_count;
  logic    res_pop;

  assign empty   = (res_count == 2'd0);
  assign result  = res_mem[res_rd_ptr];
  assign res_pop = pop & ~empty;

  // Execute one result per cycle while an operation is queued and the buffer has room
  always_comb begin
    step       = ~op_empty & (res_count != 2'd2);
    first_half = (op.kind == OP_EXPAND) & ~phase;
    cur_byte   = first_half ? CHAR_CR : op.data_byte;
    crc_cov    = cfg.crc_enable ? crc_update(crc, cur_byte) : crc;
    cnt_cov    = (count == COUNT_MAX) ? count : count + 1'b1;
    op_pop     = step & ~first_half;
    phase_next = phase;
    crc_next   = crc;
    count_next = count;
    res        = '0;
    if (step) begin
      phase_next = first_half;
      if (op.kind == OP_RESTART) begin
        crc_next     = '0;
        count_next   = '0;
        res.run_last = 1'b1;
      end else begin
        crc_next          = crc_cov;
        count_next        = cnt_cov;
        res.byte_present  = (op.kind != OP_DROP);
        res.out_byte      = (op.kind == OP_DROP) ? 8'h00 : cur_byte;
        res.crc_now       = crc_cov;
        res.bytes_counted = 32'(cnt_cov);
        res.run_last      = ~first_half;
        res.file_end      = ~first_half & op.final_byte;
      end
    end
  end

  // Running state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      crc   <= '0;
      count <= '0;
    end else begin
      phase <= phase_next;
      crc   <= crc_next;
      count <= count_next;
    end
  end

  // Result buffer storage
  always_ff @(posedge clk) begin
    if (step) begin
      res_mem[res_wr_ptr] <= res;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= 1'b0;
      res_rd_ptr <= 1'b0;
      res_count  <= 2'd0;
    end else begin
      if (step) begin
        res_wr_ptr <= ~res_wr_ptr;
      end
      if (res_pop) begin
        res_rd_ptr <= ~res_rd_ptr;
      end
      if (step && !res_pop) begin
        res_count <= res_count + 2'd1;
      end else if (!step && res_pop) begin
        res_count <= res_count - 2'd1;
      end
    end
  end

endmodule

// File: src/crc16_text_line_end_converter.sv
// Channel   Handshake                     Payload
// input     push / full                   item   (action, data_byte, final_byte)
// result    empty / pop                   result (out_byte .. file_end)
// config    psel penable pwrite pready    paddr, pwdata, prdata
//
// One input byte per cycle while the queue has room; an LF expanded to CR LF
// makes two results in the back end, which emits one result per cycle while
// its buffer has room. The front end classifies and queues up to four
// operations, so input keeps flowing during an expansion. A two-entry result
// buffer lets the back end run while pop is low; results are registered there.
// Synchronous reset clears the CRC, the count and the queues, and resets the registers.
module crc16_text_line_end_converter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  crclec_pkg::in_item_t item,
  output logic                 empty,
  input  logic                 pop,
  output crclec_pkg::result_t  result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import crclec_pkg::*;

  cfg_t       cfg;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic opq_push;
  op_t  opq_in;
  logic opq_full;
  logic opq_pop;
  op_t  opq_out;
  logic opq_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_conv  <= 1'b0;
      cfg.direction  <= DIR_ARCHIVE;
      cfg.crc_enable <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LINE_CONV:  cfg.line_conv  <= pwdata[0];
        REG_DIRECTION:  cfg.direction  <= pwdata[0];
        REG_CRC_ENABLE: cfg.crc_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_LINE_CONV:  prdata = {31'b0, cfg.line_conv};
      REG_DIRECTION:  prdata = {31'b0, cfg.direction};
      REG_CRC_ENABLE: prdata = {31'b0, cfg.crc_enable};
      default:        prdata = 32'b0;
    endcase
  end

  crclec_front u_front (
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .item     (item),
    .op_push  (opq_push),
    .op       (opq_in),
    .opq_full (opq_full)
  );

  crclec_opq u_opq (
    .clk    (clk),
    .rst    (rst),
    .push   (opq_push),
    .op_in  (opq_in),
    .full   (opq_full),
    .pop    (opq_pop),
    .op_out (opq_out),
    .empty  (opq_empty)
  );

  crclec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op_empty (opq_empty),
    .op       (opq_out),
    .op_pop   (opq_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import crclec_pkg::*;

  // Unmapped register slot, used to check that writes there are ignored
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int PHASE_ITEMS = 250;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  in_item_t    item_bus;
  logic        empty;
  logic        pop;
  result_t     result_bus;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crc16_text_line_end_converter u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item_bus),
    .empty   (empty),
    .pop     (pop),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the converter state and its mode registers
  logic [15:0]           model_crc;
  logic [COUNT_BITS-1:0] model_count;
  logic                  cfg_line_conv;
  logic                  cfg_direction;
  logic                  cfg_crc_enable;
  result_t               expected_out[$];

  int fail_count;
  int n_items;
  int n_results;
  int n_expand;
  int n_drop;
  int n_restart;

  // Sender burst control and receiver stall pattern
  int burst_left;
  bit tx_no_idle;
  int rx_mode;
  int rx_hold;
  int rx_tick;

  always #6 clk = ~clk;

  // Reflected CRC-16, one input bit at a time, LSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // A byte that enters the checksum and the count
  function automatic void count_byte(input logic [7:0] b);
    if (cfg_crc_enable) model_crc = crc16_step(model_crc, b);
    if (model_count != COUNT_MAX) model_count = model_count + 1'b1;
  endfunction

  function automatic void queue_result(input logic [7:0] b, input logic present,
                                       input logic last, input logic fend);
    result_t r;
    r.out_byte      = b;
    r.byte_present  = present;
    r.crc_now       = model_crc;
    r.bytes_counted = 32'(model_count);
    r.run_last      = last;
    r.file_end      = fend;
    expected_out.push_back(r);
  endfunction

  // Expected results of one accepted input transaction
  function automatic void predict_conversion(input in_item_t it);
    if (it.action == ACT_RESTART) begin
      model_crc   = '0;
      model_count = '0;
      queue_result(8'h00, 1'b0, 1'b1, 1'b0);
      n_restart++;
    end else if (cfg_line_conv && cfg_direction == DIR_ARCHIVE && it.data_byte == CHAR_LF) begin
      count_byte(CHAR_CR);
      queue_result(CHAR_CR, 1'b1, 1'b0, 1'b0);
      count_byte(CHAR_LF);
      queue_result(CHAR_LF, 1'b1, 1'b1, it.final_byte);
      n_expand++;
    end else begin
      count_byte(it.data_byte);
      if (cfg_line_conv && cfg_direction == DIR_EXTRACT && it.data_byte == CHAR_CR) begin
        queue_result(8'h00, 1'b0, 1'b1, it.final_byte);
        n_drop++;
      end else begin
        queue_result(it.data_byte, 1'b1, 1'b1, it.final_byte);
      end
    end
  endfunction

  function automatic in_item_t mk_item(input logic act, input logic [7:0] b, input logic fin);
    in_item_t it;
    it.action     = act;
    it.data_byte  = b;
    it.final_byte = fin;
    return it;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Send one input transaction; random gaps fall between bursts
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = tx_no_idle ? 0 : $urandom_range(7, 0);
      burst_left = $urandom_range(24, 1);
    end
    @(negedge clk);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push     = 1'b1;
    item_bus = it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_conversion(it);
    n_items++;
    burst_left--;
  endtask

  // Stop sending and wait until every expected result has come out
  task automatic drain;
    @(negedge clk);
    push = 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write, then read back mapped registers
  task automatic cfg_write(input logic [1:0] idx, input logic value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {31'b0, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_LINE_CONV:  cfg_line_conv  = value;
      REG_DIRECTION:  cfg_direction  = value;
      REG_CRC_ENABLE: cfg_crc_enable = value;
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx != REG_UNMAPPED) begin
      @(negedge clk);
      psel = 1'b1;
      @(negedge clk);
      penable = 1'b1;
      @(posedge clk);
      compare_field("prdata", {31'b0, value}, prdata);
      @(negedge clk);
      psel    = 1'b0;
      penable = 1'b0;
    end
  endtask

  task automatic cfg_apply(input logic text, input logic dir, input logic crc_on);
    drain();
    cfg_write(REG_LINE_CONV, text);
    cfg_write(REG_DIRECTION, dir);
    cfg_write(REG_CRC_ENABLE, crc_on);
  endtask

  // Reset values: binary copy, CRC on; a restart ignores its other fields
  task automatic test_binary_defaults;
    send_item(mk_item(ACT_DATA, 8'h00, 1'b0));
    send_item(mk_item(ACT_DATA, 8'hFF, 1'b0));
    send_item(mk_item(ACT_DATA, CHAR_LF, 1'b0));
    send_item(mk_item(ACT_DATA, CHAR_CR, 1'b0));
    send_item(mk_item(ACT_DATA, 8'h55, 1'b1));
    send_item(mk_item(ACT_RESTART, 8'hFF, 1'b1));
    send_item(mk_item(ACT_DATA, 8'hAA, 1'b0));
  endtask

  // Archive direction: LF goes out as CR LF, CR passes
  task automatic test_archive_text;
    cfg_apply(1'b1, DIR_ARCHIVE, 1'b1);
    send_item(mk_item(ACT_DATA, CHAR_LF, 1'b0));
    send_item(mk_item(ACT_DATA, CHAR_LF, 1'b1));
    send_item(mk_item(ACT_DATA, CHAR_CR, 1'b0));
    send_item(mk_item(ACT_DATA, 8'h41, 1'b1));
  endtask

  // Extract direction: CR dropped but still counted
  task automatic test_extract_text;
    cfg_apply(1'b1, DIR_EXTRACT, 1'b1);
    send_item(mk_item(ACT_DATA, CHAR_CR, 1'b0));
    send_item(mk_item(ACT_DATA, CHAR_CR, 1'b1));
    send_item(mk_item(ACT_DATA, CHAR_LF, 1'b0));
    send_item(mk_item(ACT_DATA, 8'h80, 1'b0));
  endtask

  // Direction has no effect in binary mode
  task automatic test_binary_extract;
    cfg_apply(1'b0, DIR_EXTRACT, 1'b1);
    send_item(mk_item(ACT_DATA, CHAR_CR, 1'b0));
    send_item(mk_item(ACT_DATA, CHAR_LF, 1'b1));
  endtask

  // CRC held while the count still moves; unmapped register write ignored
  task automatic test_crc_disabled;
    cfg_apply(1'b1, DIR_ARCHIVE, 1'b0);
    cfg_write(REG_UNMAPPED, 1'b1);
    send_item(mk_item(ACT_DATA, CHAR_LF, 1'b0));
    send_item(mk_item(ACT_DATA, 8'h33, 1'b0));
    send_item(mk_item(ACT_RESTART, 8'h00, 1'b0));
    send_item(mk_item(ACT_DATA, CHAR_CR, 1'b1));
  endtask

  function automatic logic [7:0] rand_text_byte;
    int r;
    r = $urandom_range(99, 0);
    if (r < 15) return CHAR_LF;
    if (r < 30) return CHAR_CR;
    if (r < 33) return 8'h1A;
    return 8'($urandom_range(255, 0));
  endfunction

  // Random files under every mode setting: restart, bytes, final byte, plus noise
  task automatic test_random_modes;
    int       phase_start;
    int       len;
    logic [2:0] m;
    for (int ph = 0; ph < 8; ph++) begin
      m = 3'(ph);
      cfg_apply(m[0], m[1], ~m[2]);
      tx_no_idle  = (ph == 5);
      phase_start = n_items;
      while (n_items - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(19, 0) != 0)
          send_item(mk_item(ACT_RESTART, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0))));
        len = $urandom_range(30, 1);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99, 0) < 3)
            send_item(mk_item(ACT_RESTART, rand_text_byte(), 1'($urandom_range(1, 0))));
          else
            send_item(mk_item(ACT_DATA, rand_text_byte(),
                              (k == len - 1) || ($urandom_range(49, 0) == 0)));
        end
      end
    end
    tx_no_idle = 1'b0;
  endtask

  // Receiver: picks a new random pop pattern whenever its hold counter runs out
  always @(negedge clk) begin
    rx_tick++;
    if (rx_hold == 0) begin
      rx_mode = $urandom_range(3, 0);
      rx_hold = $urandom_range(200, 30);
    end else begin
      rx_hold--;
    end
    case (rx_mode)
      0:       pop = 1'b1;
      1:       pop = 1'($urandom_range(1, 0));
      2:       pop = ($urandom_range(7, 0) == 0);
      default: pop = ((rx_tick % 16) < 5);
    endcase
  end

  // Compare each popped result with the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && pop && !empty) begin
      n_results++;
      if (expected_out.size() == 0) begin
        $error("unexpected result transaction: out_byte 0x%0h", result_bus.out_byte);
        fail_count++;
      end else begin
        exp_r = expected_out.pop_front();
        compare_field("out_byte", exp_r.out_byte, result_bus.out_byte);
        compare_field("byte_present", exp_r.byte_present, result_bus.byte_present);
        compare_field("crc_now", exp_r.crc_now, result_bus.crc_now);
        compare_field("bytes_counted", exp_r.bytes_counted, result_bus.bytes_counted);
        compare_field("run_last", exp_r.run_last, result_bus.run_last);
        compare_field("file_end", exp_r.file_end, result_bus.file_end);
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    push           = 1'b0;
    item_bus       = '0;
    pop            = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    model_crc      = '0;
    model_count    = '0;
    cfg_line_conv  = 1'b0;
    cfg_direction  = DIR_ARCHIVE;
    cfg_crc_enable = 1'b1;
    fail_count     = 0;
    n_items        = 0;
    n_results      = 0;
    n_expand       = 0;
    n_drop         = 0;
    n_restart      = 0;
    burst_left     = 0;
    tx_no_idle     = 1'b0;
    rx_mode        = 0;
    rx_hold        = 0;
    rx_tick        = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_binary_defaults();
    test_archive_text();
    test_extract_text();
    test_binary_extract();
    test_crc_disabled();
    test_random_modes();

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d input transactions and %0d results across all eight mode settings",
             n_items, n_results);
    $display("  %0d LF expansions, %0d dropped CRs, %0d restarts", n_expand, n_drop, n_restart);
    if (fail_count == 0 && expected_out.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
